// ----- hw/rtl/burst_pwm_channel_generator_assert.svh -----
// Assertion macros for the burst PWM channel generator checker.
`ifndef BURST_PWM_CHANNEL_GENERATOR_ASSERT_SVH
`define BURST_PWM_CHANNEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, off while reset is active.
`define BPWM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bpwm check failed");

// Next-cycle implication, off while reset is active.
`define BPWM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bpwm check failed");

// State right after a reset cycle.
`define BPWM_ASSERT_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error("bpwm reset check failed");

`endif

// ----- hw/rtl/bpwm_pkg.sv -----
package bpwm_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 8;
    localparam int unsigned QUEUE_DEPTH_DEF  = 2;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned OUT_CH     = 8;

    localparam logic [6:0] DUTY_MAX    = 7'd100;
    localparam logic [7:0] REP_ENDLESS = 8'hFF;

    // floor(p / 100) = (p * ceil(2^30 / 100)) >> 30, exact for p < 2^23
    localparam int unsigned    PROD_W    = 23;
    localparam int unsigned    RECIP_W   = 24;
    localparam int unsigned    RECIP_SH  = 30;
    localparam logic [23:0]    RECIP_100 = 24'd10737419;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        t_req        op;
        logic [2:0]  ch;
        logic [15:0] period;
        logic [6:0]  duty;
        logic [7:0]  burst;
        logic [7:0]  sleep;
        logic        slvl;
        logic [7:0]  rep;
        logic        stoplvl;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_rd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_RECIP,
        ST_LOAD,
        ST_TICK,
        ST_RESULT
    } t_state;

endpackage

// ----- hw/rtl/burst_pwm_channel_generator.sv -----
// Burst PWM channel generator, NUM_CHANNELS channels.
// Slave stream: one request per transfer. tuser = request kind (tick all,
// start channel, stop channel); tdata carries the channel and the start
// settings. Master stream: one transfer per request with every pin level
// and running flag.
// A tick walks the channel table once, one channel per cycle. A start goes
// through the period*duty product, the reciprocal multiply for /100, the
// table write and the result; a stop or an unknown request goes straight to
// its result. The back takes one request at a time: it pops the next one
// only from its idle state, once the last result is in the output register;
// the walk of the channel table bounds the rate of ticks.
// Requests land in a short queue; the front keeps taking transfers while
// the back works and while a result waits in the output register.
// When the receiver stalls, the output register holds its result, the back
// halts in its result state and the queue fills, then tready drops.
// Reset: all channels stopped, pins low, queue empty, tready low for the
// reset cycle and the one after.
module burst_pwm_channel_generator #(
    parameter int unsigned NUM_CHANNELS = bpwm_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned QUEUE_DEPTH  = bpwm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [2:0] channel, [18:3] period_ticks, [25:19] duty_percent,
    // [33:26] burst_cycles, [41:34] sleep_cycles, [42] sleep_level_in,
    // [50:43] repeat_count, [51] stop_level_in, [55:52] zero
    input  logic [bpwm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [bpwm_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] pin_levels, [15:8] running_flags
    output logic [bpwm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import bpwm_pkg::*;

    t_q_wr w_q_wr;
    t_q_rd w_q_rd;
    logic  w_q_full, w_q_pop;

    // classify and saturate incoming requests
    bpwm_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_q_wr     (w_q_wr)
    );

    // decouples acceptance from the channel walk
    bpwm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_rd    (w_q_rd)
    );

    // channel table, tick sequencer and output register
    bpwm_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_rd     (w_q_rd),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- hw/rtl/bpwm_front.sv -----
module bpwm_front #(
    parameter int unsigned NUM_CHANNELS = bpwm_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bpwm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [bpwm_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_q_full,
    output bpwm_pkg::t_q_wr                 o_q_wr
);
    import bpwm_pkg::*;

    logic [2:0] w_ch;
    logic [6:0] w_duty;
    logic       w_in_range;
    t_req       w_req;

    assign w_ch       = i_s_tdata[2:0];
    assign w_duty     = i_s_tdata[25:19];
    assign w_in_range = (32'(w_ch) < NUM_CHANNELS);
    assign w_req      = t_req'(i_s_tuser);

    assign o_s_tready = !i_q_full;

    always_comb begin
        o_q_wr.push        = i_s_tvalid && !i_q_full;
        o_q_wr.cmd.ch      = w_ch;
        o_q_wr.cmd.period  = i_s_tdata[18:3];
        o_q_wr.cmd.duty    = (w_duty > DUTY_MAX) ? DUTY_MAX : w_duty;
        o_q_wr.cmd.burst   = i_s_tdata[33:26];
        o_q_wr.cmd.sleep   = i_s_tdata[41:34];
        o_q_wr.cmd.slvl    = i_s_tdata[42];
        o_q_wr.cmd.rep     = i_s_tdata[50:43];
        o_q_wr.cmd.stoplvl = i_s_tdata[51];
        // start or stop aimed past the last channel does nothing
        unique case (w_req)
            REQ_START, REQ_STOP: o_q_wr.cmd.op = w_in_range ? w_req : REQ_NONE;
            REQ_TICK:            o_q_wr.cmd.op = REQ_TICK;
            default:             o_q_wr.cmd.op = REQ_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/bpwm_queue.sv -----
module bpwm_queue #(
    parameter int unsigned DEPTH = bpwm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpwm_pkg::t_q_wr i_wr,
    output logic            o_full,
    input  logic            i_pop,
    output bpwm_pkg::t_q_rd o_rd
);
    import bpwm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             r_up;
    logic             w_push, w_pop;

    assign o_full     = !r_up || (r_count == CNT_W'(DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.cmd   = r_mem[r_rptr];
    assign w_push     = i_wr.push && !o_full;
    assign w_pop      = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_up    <= 1'b0;
        end else begin
            r_up <= 1'b1;
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wr.cmd;
        end
    end

endmodule

// ----- hw/rtl/bpwm_back.sv -----
module bpwm_back #(
    parameter int unsigned NUM_CHANNELS = bpwm_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpwm_pkg::t_q_rd                 i_q_rd,
    output logic                            o_q_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bpwm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import bpwm_pkg::*;

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W+RECIP_W-1:0] r_recip;

    logic [15:0] r_period [NUM_CHANNELS];
    logic [15:0] r_hi     [NUM_CHANNELS];
    logic [15:0] r_cnt    [NUM_CHANNELS];
    logic [7:0]  r_burst  [NUM_CHANNELS];
    logic [7:0]  r_sleep  [NUM_CHANNELS];
    logic [7:0]  r_phase  [NUM_CHANNELS];
    logic [7:0]  r_rep    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_stoplvl;
    logic [NUM_CHANNELS-1:0] r_run, r_fhigh, r_fslvl, r_fsleep, r_fhalf, r_pin;

    logic r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic w_pop, w_stop, w_load, w_tick, w_result, w_last;
    logic [IDX_W-1:0] w_cidx;
    logic [15:0] w_hi;

    // per-channel tick update
    logic [15:0] t_cnt;
    logic [7:0]  t_phase, t_rep;
    logic        t_run, t_high, t_sleep, t_half, t_pin, t_halt;

    assign w_cidx = IDX_W'(r_cmd.ch);
    assign w_hi   = r_recip[RECIP_SH +: 16];
    assign w_last = (r_idx == IDX_W'(NUM_CHANNELS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_q_rd.valid) n_state = ST_DECODE;
            ST_DECODE: begin
                unique case (r_cmd.op)
                    REQ_TICK:  n_state = ST_TICK;
                    REQ_START: n_state = ST_MUL;
                    default:   n_state = ST_RESULT;
                endcase
            end
            ST_MUL:    n_state = ST_RECIP;
            ST_RECIP:  n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_RESULT;
            ST_TICK:   if (w_last) n_state = ST_RESULT;
            ST_RESULT: if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_pop    = (r_state == ST_IDLE) && i_q_rd.valid;
        w_stop   = (r_state == ST_DECODE) && (r_cmd.op == REQ_STOP);
        w_load   = (r_state == ST_LOAD);
        w_tick   = (r_state == ST_TICK);
        w_result = (r_state == ST_RESULT) && (!r_out_valid || i_m_tready);
    end

    assign o_q_pop = w_pop;

    always_comb begin
        t_cnt   = r_cnt[r_idx];
        t_phase = r_phase[r_idx];
        t_rep   = r_rep[r_idx];
        t_run   = r_run[r_idx];
        t_high  = r_fhigh[r_idx];
        t_sleep = r_fsleep[r_idx];
        t_half  = r_fhalf[r_idx];
        t_pin   = r_pin[r_idx];
        t_halt  = 1'b0;
        if (t_run) begin
            if (t_cnt != '0) begin
                t_cnt = t_cnt - 1'b1;
            end else begin
                if (t_phase == '0) begin
                    t_sleep = !t_sleep;
                    if (!t_sleep) begin
                        if (t_rep != REP_ENDLESS) begin
                            if (t_rep != '0) t_rep = t_rep - 1'b1;
                            else             t_halt = 1'b1;
                        end
                        t_phase = r_burst[r_idx];
                    end else begin
                        t_phase = r_sleep[r_idx];
                    end
                end else if (t_half) begin
                    t_phase = t_phase - 1'b1;
                end
                if (!t_sleep) begin
                    t_high = !t_high;
                    t_cnt  = t_high ? r_hi[r_idx] : r_period[r_idx] - r_hi[r_idx];
                    t_pin  = !t_pin;
                end else begin
                    t_pin  = r_fslvl[r_idx];
                    t_cnt  = {1'b0, r_period[r_idx][15:1]};
                end
                t_half = !t_half;
                if (t_halt) begin
                    t_pin   = r_stoplvl[r_idx];
                    t_run   = 1'b0;
                    t_high  = 1'b0;
                    t_sleep = 1'b0;
                    t_half  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_run       <= '0;
            r_fhigh     <= '0;
            r_fslvl     <= '0;
            r_fsleep    <= '0;
            r_fhalf     <= '0;
            r_pin       <= '0;
        end else begin
            r_state <= n_state;
            if (w_pop) r_idx <= '0;
            else if (w_tick) r_idx <= r_idx + 1'b1;
            if (w_result)        r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
            if (w_stop) begin
                r_pin[w_cidx]    <= r_cmd.stoplvl;
                r_run[w_cidx]    <= 1'b0;
                r_fhigh[w_cidx]  <= 1'b0;
                r_fslvl[w_cidx]  <= 1'b0;
                r_fsleep[w_cidx] <= 1'b0;
                r_fhalf[w_cidx]  <= 1'b0;
            end
            if (w_load) begin
                r_run[w_cidx]   <= 1'b1;
                r_fslvl[w_cidx] <= r_cmd.slvl;
            end
            if (w_tick) begin
                r_run[r_idx]    <= t_run;
                r_fhigh[r_idx]  <= t_high;
                r_fsleep[r_idx] <= t_sleep;
                r_fhalf[r_idx]  <= t_half;
                r_pin[r_idx]    <= t_pin;
                if (t_halt) r_fslvl[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) r_cmd <= i_q_rd.cmd;
        r_prod  <= PROD_W'(r_cmd.period) * PROD_W'(r_cmd.duty);
        r_recip <= (PROD_W+RECIP_W)'(r_prod) * (PROD_W+RECIP_W)'(RECIP_100);
        if (w_load) begin
            r_period[w_cidx]  <= r_cmd.period;
            r_hi[w_cidx]      <= w_hi;
            r_cnt[w_cidx]     <= w_hi;
            r_burst[w_cidx]   <= r_cmd.burst;
            r_phase[w_cidx]   <= r_cmd.burst;
            r_sleep[w_cidx]   <= r_cmd.sleep;
            r_rep[w_cidx]     <= r_cmd.rep - 1'b1;
            r_stoplvl[w_cidx] <= r_cmd.stoplvl;
        end
        if (w_tick) begin
            r_cnt[r_idx]   <= t_cnt;
            r_phase[r_idx] <= t_phase;
            r_rep[r_idx]   <= t_rep;
        end
        if (w_result) begin
            for (int c = 0; c < OUT_CH; c++) begin
                if (c < NUM_CHANNELS) begin
                    r_out_data[c]          <= r_pin[c];
                    r_out_data[OUT_CH + c] <= r_run[c];
                end else begin
                    r_out_data[c]          <= 1'b0;
                    r_out_data[OUT_CH + c] <= 1'b0;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- hw/rtl/bpwm_checker.sv -----
`include "burst_pwm_channel_generator_assert.svh"

module bpwm_checker #(
    parameter int unsigned QUEUE_DEPTH = bpwm_pkg::QUEUE_DEPTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [bpwm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    // queue, back stage and output register
    localparam int unsigned PEND_MAX = QUEUE_DEPTH + 2;
    localparam int unsigned PEND_W   = $clog2(PEND_MAX + 2);

    logic [PEND_W-1:0] r_pend;
    logic w_in_xfer, w_out_xfer;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(w_in_xfer) - PEND_W'(w_out_xfer);
        end
    end

    `BPWM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `BPWM_ASSERT_RST(a_reset_idle, i_clk, i_rst_n, !o_m_tvalid && !o_s_tready)
    `BPWM_ASSERT_IMP(a_no_extra, i_clk, i_rst_n, w_out_xfer, r_pend != '0)
    `BPWM_ASSERT_IMP(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend <= PEND_W'(PEND_MAX))

endmodule

bind burst_pwm_channel_generator bpwm_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_bpwm_checker (.*);

// ----- sim/burst_pwm_channel_generator_test.sv -----
`timescale 1ns / 1ps

// Burst PWM generator check: a per-channel model of every pin is kept in
// step with the accepted requests; each result transfer is compared with it.
class pwm_scoreboard;
    logic [15:0] period_q [8];
    logic [6:0]  duty_q   [8];
    logic [7:0]  burst_q  [8];
    logic [7:0]  sleep_q  [8];
    logic [15:0] countdown[8];
    logic [7:0]  phase_left[8];
    logic [7:0]  rounds_left[8];
    logic        stop_lvl [8];
    logic        running  [8];
    logic        high_half[8];
    logic        sleep_lvl[8];
    logic        sleeping [8];
    logic        second_half[8];
    logic        pin      [8];
    logic [15:0] levels_q[$];
    int          errors;

    function new();
        for (int c = 0; c < 8; c++) begin
            period_q[c] = 0; duty_q[c] = 0; burst_q[c] = 0; sleep_q[c] = 0;
            countdown[c] = 0; phase_left[c] = 0; rounds_left[c] = 0;
            stop_lvl[c] = 0; running[c] = 0; high_half[c] = 0; sleep_lvl[c] = 0;
            sleeping[c] = 0; second_half[c] = 0; pin[c] = 0;
        end
        errors = 0;
    endfunction

    function logic [15:0] high_time(int c);
        logic [31:0] prod;
        prod = period_q[c] * duty_q[c];
        return 16'(prod / 100);
    endfunction

    function void halt(int c, logic lvl);
        pin[c] = lvl;
        running[c] = 0; high_half[c] = 0; sleep_lvl[c] = 0;
        sleeping[c] = 0; second_half[c] = 0;
    endfunction

    function void advance(int c);
        logic [15:0] hi;
        if (!running[c]) return;
        if (countdown[c] != 0) begin
            countdown[c]--;
            return;
        end
        if (phase_left[c] == 0) begin
            sleeping[c] = !sleeping[c];
            if (!sleeping[c]) begin
                if (rounds_left[c] != bpwm_pkg::REP_ENDLESS) begin
                    if (rounds_left[c] != 0) rounds_left[c]--;
                    else begin
                        halt(c, stop_lvl[c]);
                        return;
                    end
                end
                phase_left[c] = burst_q[c];
            end else begin
                phase_left[c] = sleep_q[c];
            end
        end else if (second_half[c]) begin
            phase_left[c]--;
        end
        if (!sleeping[c]) begin
            hi = high_time(c);
            high_half[c] = !high_half[c];
            countdown[c] = high_half[c] ? hi : period_q[c] - hi;
            pin[c] = !pin[c];
        end else begin
            pin[c] = sleep_lvl[c];
            countdown[c] = period_q[c] >> 1;
        end
        second_half[c] = !second_half[c];
    endfunction

    // note one accepted request and queue the levels it must produce
    function void note_request(bpwm_pkg::t_req op, logic [55:0] d);
        int c;
        logic [15:0] word;
        c = int'(d[2:0]);
        case (op)
            bpwm_pkg::REQ_TICK: for (int k = 0; k < 8; k++) advance(k);
            bpwm_pkg::REQ_START: begin
                period_q[c] = d[18:3];
                duty_q[c] = (d[25:19] > bpwm_pkg::DUTY_MAX) ? bpwm_pkg::DUTY_MAX : d[25:19];
                burst_q[c] = d[33:26];
                phase_left[c] = d[33:26];
                sleep_q[c] = d[41:34];
                countdown[c] = high_time(c);
                running[c] = 1;
                sleep_lvl[c] = d[42];
                rounds_left[c] = d[50:43] - 8'd1;
                stop_lvl[c] = d[51];
            end
            bpwm_pkg::REQ_STOP: halt(c, d[51]);
            default: ;
        endcase
        for (int k = 0; k < 8; k++) begin
            word[k] = pin[k];
            word[8 + k] = running[k];
        end
        levels_q.push_back(word);
    endfunction

    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (levels_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = levels_q.pop_front();
        if (got[7:0] !== want[7:0]) begin
            $display("%0t: pin_levels expected %h got %h", $time, want[7:0], got[7:0]);
            errors++;
        end
        if (got[15:8] !== want[15:8]) begin
            $display("%0t: running_flags expected %h got %h", $time, want[15:8], got[15:8]);
            errors++;
        end
    endfunction
endclass

module burst_pwm_channel_generator_test;
    import bpwm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [55:0] i_s_tdata;   // channel, period, duty, burst, sleep, slvl, rep, stoplvl, zero
    logic [1:0]  i_s_tuser;   // req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // pin_levels, running_flags

    pwm_scoreboard board;
    bit   quiet_sender;       // no random gaps
    bit   quiet_receiver;     // no random stalls
    bit   hold_receiver;      // long hold-off
    int   idle_cycles;

    burst_pwm_channel_generator DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = !i_clk;
    end

    // offer one request, hold it until the transfer happens; tvalid stays
    // up after the transfer unless a gap follows or the caller drops it
    task automatic send_request(t_req op, logic [55:0] d);
        while (!quiet_sender && $urandom_range(99) < 18) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= op;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(op, d);
        @(negedge i_clk);
    endtask

    function automatic logic [55:0] pack_start(int ch, int per, int duty, int bur, int slp,
                                               bit slvl, int rep, bit stl);
        logic [55:0] d;
        d = '0;
        d[2:0] = 3'(ch); d[18:3] = 16'(per); d[25:19] = 7'(duty); d[33:26] = 8'(bur);
        d[41:34] = 8'(slp); d[42] = slvl; d[50:43] = 8'(rep); d[51] = stl;
        return d;
    endfunction

    function automatic logic [55:0] rand_data();
        return 56'({$urandom, $urandom});
    endfunction

    task automatic random_start(bit tiny);
        send_request(REQ_START, pack_start($urandom_range(7),
            tiny ? $urandom_range(6) : $urandom_range(65535),
            $urandom_range(127), tiny ? $urandom_range(4) : $urandom_range(255),
            tiny ? $urandom_range(4) : $urandom_range(255), $urandom_range(1),
            tiny ? $urandom_range(4) : $urandom_range(255), $urandom_range(1)));
    endtask

    // receiver: random stalls, long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_receiver) i_m_tready <= 0;
        else i_m_tready <= quiet_receiver || ($urandom_range(99) >= 18);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int r;
        board = new();
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0; i_s_tuser = REQ_TICK;
        i_m_tready = 0; quiet_sender = 0; quiet_receiver = 0; hold_receiver = 0;
        idle_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, all request kinds, saturation, restart
        send_request(REQ_TICK, '0);
        send_request(REQ_START, pack_start(0, 0, 0, 0, 0, 0, 0, 0));
        send_request(REQ_START, pack_start(7, 65535, 127, 255, 255, 1, 255, 1));
        send_request(REQ_START, pack_start(1, 65535, 100, 1, 1, 1, 1, 1));
        send_request(REQ_START, pack_start(2, 3, 50, 2, 2, 1, 2, 0));
        send_request(REQ_START, pack_start(3, 4, 101, 1, 0, 0, 1, 1));
        send_request(REQ_START, pack_start(4, 2, 0, 0, 3, 1, 0, 1));
        send_request(REQ_NONE, '1);
        repeat (8) send_request(REQ_TICK, '0);
        send_request(REQ_START, pack_start(2, 5, 20, 3, 1, 0, 3, 1)); // restart while running
        send_request(REQ_STOP, pack_start(7, 0, 0, 0, 0, 0, 0, 1));
        send_request(REQ_STOP, pack_start(0, 0, 0, 0, 0, 0, 0, 0));
        send_request(REQ_NONE, pack_start(5, 9, 9, 9, 9, 1, 9, 1));
        repeat (5) send_request(REQ_TICK, '1);

        // back-pressure: receiver holds off while the sender keeps offering
        fork
            begin
                hold_receiver = 1;
                repeat (300) @(posedge i_clk);
                hold_receiver = 0;
            end
            repeat (12) send_request(REQ_TICK, '0);
        join
        i_s_tvalid <= 0;

        // sender pauses until all results are in
        while (board.levels_q.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);

        // random: mostly short-period starts with ticks so phases and repeats complete
        for (int n = 0; n < 1300; n++) begin
            quiet_sender = (n >= 500 && n < 650);
            quiet_receiver = quiet_sender;
            r = $urandom_range(99);
            if (r < 62) send_request(REQ_TICK, rand_data());
            else if (r < 82) random_start(1);
            else if (r < 88) random_start(0);
            else if (r < 95) send_request(REQ_STOP, rand_data());
            else send_request(REQ_NONE, rand_data());
        end
        i_s_tvalid <= 0;
        quiet_sender = 0; quiet_receiver = 0;

        while (board.levels_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.levels_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
